// ===== rtl/core/assert_macros.svh =====
// assertion helper macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/ibp_pkg.sv =====
// shared constants, types and helpers for the border padding block
`timescale 1ns / 1ps

package ibp_pkg;

    localparam int MAX_WIDTH     = 64;
    localparam int MAX_HEIGHT    = 64;
    localparam int PIXEL_BITS    = 32;
    localparam int MAX_PAD       = 63;

    localparam int X_BITS        = $clog2(MAX_WIDTH);
    localparam int Y_BITS        = $clog2(MAX_HEIGHT);
    localparam int IDX_BITS      = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
    localparam int ADDR_BITS     = X_BITS + Y_BITS;
    localparam int STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;

    localparam int LEN_BITS      = 7;
    localparam int PAD_BITS      = 6;
    localparam int COORD_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 7;

    // restoring reduction: subtract len << s for s from MOD_SHIFT_TOP down to 0
    localparam int MOD_SHIFT_TOP = 6;
    localparam int SHIFT_BITS    = $clog2(MOD_SHIFT_TOP + 1);
    localparam int SUB_BITS      = LEN_BITS + MOD_SHIFT_TOP;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAD_LEFT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAD_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAD_TOP    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAD_BOTTOM = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_MODE  = 3'd6;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // edge modes
    localparam logic EDGE_REPLICATE = 1'b0;
    localparam logic EDGE_MIRROR    = 1'b1;

    // one axis mapping request
    typedef struct packed {
        logic [COORD_BITS-1:0] d;
        logic [PAD_BITS-1:0]   pad;
        logic [LEN_BITS-1:0]   len;
        logic                  mirror;
    } t_axis_req;

    // mapping answer, idx valid while done is high
    typedef struct packed {
        logic                done;
        logic [IDX_BITS-1:0] idx;
    } t_axis_rsp;

    // zero length counts as one, oversize clamps to the store size
    function automatic logic [LEN_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] v,
                                                      input logic [LEN_BITS-1:0] maxv);
        logic [LEN_BITS-1:0] res;
        if (v == '0) begin
            res = LEN_BITS'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [PAD_BITS-1:0] clamp_pad(input logic [PAD_BITS-1:0] v);
        logic [PAD_BITS:0] lim;
        lim = (PAD_BITS + 1)'(MAX_PAD);
        return ({1'b0, v} > lim) ? PAD_BITS'(MAX_PAD) : v;
    endfunction

endpackage

// ===== rtl/core/ibp_frame_store.sv =====
// source frame pixel store, one write and one registered read port
`timescale 1ns / 1ps

module ibp_frame_store (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [ibp_pkg::ADDR_BITS-1:0]  i_wr_addr,
    input  logic [ibp_pkg::PIXEL_BITS-1:0] i_wr_data,
    input  logic                           i_rd_en,
    input  logic [ibp_pkg::ADDR_BITS-1:0]  i_rd_addr,
    output logic [ibp_pkg::PIXEL_BITS-1:0] o_rd_data
);
    import ibp_pkg::*;

    logic [PIXEL_BITS-1:0] r_mem [STORE_DEPTH];
    logic [PIXEL_BITS-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/ibp_axis_unit.sv =====
// shared axis mapper: edge clamp, mirror and iterative wrap by the axis length
`timescale 1ns / 1ps

module ibp_axis_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ibp_pkg::t_axis_req i_req,
    output ibp_pkg::t_axis_rsp o_rsp
);
    import ibp_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_RED  = 3'b010,
        U_DONE = 3'b100
    } t_ustate;

    t_ustate               r_state, n_state;
    logic [LEN_BITS-1:0]   r_v, n_v;
    logic                  r_neg, n_neg;
    logic [SHIFT_BITS-1:0] r_shift, n_shift;
    logic [IDX_BITS-1:0]   r_idx, n_idx;

    logic                  w_below;
    logic                  w_inside;
    logic [COORD_BITS:0]   w_rel;
    logic [COORD_BITS:0]   w_t;
    logic [PAD_BITS-1:0]   w_k;
    logic [SUB_BITS-1:0]   w_shifted;
    logic                  w_ge;
    logic                  w_less;
    logic [LEN_BITS-1:0]   w_flip;

    // classify the coordinate against the padded axis
    assign w_below  = i_req.d < COORD_BITS'(i_req.pad);
    assign w_rel    = (COORD_BITS + 1)'(i_req.d) - (COORD_BITS + 1)'(i_req.pad);
    assign w_inside = w_rel < (COORD_BITS + 1)'(i_req.len);
    assign w_t      = w_rel - (COORD_BITS + 1)'(i_req.len) + (COORD_BITS + 1)'(2);
    assign w_k      = i_req.pad - i_req.d[PAD_BITS-1:0];

    // the shared compare and subtract step
    assign w_shifted = SUB_BITS'(i_req.len) << r_shift;
    assign w_ge      = SUB_BITS'(r_v) >= w_shifted;
    assign w_less    = r_v < i_req.len;
    assign w_flip    = (r_v == '0) ? '0 : (i_req.len - r_v);

    always_comb begin
        n_state = r_state;
        n_v     = r_v;
        n_neg   = r_neg;
        n_shift = r_shift;
        n_idx   = r_idx;
        unique case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    priority if (w_below) begin
                        if (i_req.mirror == EDGE_MIRROR) begin
                            n_v     = LEN_BITS'(w_k);
                            n_neg   = 1'b0;
                            n_shift = SHIFT_BITS'(MOD_SHIFT_TOP);
                            n_state = U_RED;
                        end else begin
                            n_idx   = '0;
                            n_state = U_DONE;
                        end
                    end else if (w_inside) begin
                        n_idx   = w_rel[IDX_BITS-1:0];
                        n_state = U_DONE;
                    end else if (i_req.mirror == EDGE_REPLICATE) begin
                        n_idx   = IDX_BITS'(i_req.len - LEN_BITS'(1));
                        n_state = U_DONE;
                    end else if (w_t <= (COORD_BITS + 1)'(i_req.len)) begin
                        n_idx   = IDX_BITS'(i_req.len - w_t[LEN_BITS-1:0]);
                        n_state = U_DONE;
                    end else begin
                        n_v     = w_t[LEN_BITS-1:0];
                        n_neg   = 1'b1;
                        n_shift = SHIFT_BITS'(MOD_SHIFT_TOP);
                        n_state = U_RED;
                    end
                end
            end
            U_RED: begin
                // one shifted subtract per cycle until below the length
                if (w_less) begin
                    n_idx   = r_neg ? IDX_BITS'(w_flip) : IDX_BITS'(r_v);
                    n_state = U_DONE;
                end else begin
                    if (w_ge) begin
                        n_v = r_v - w_shifted[LEN_BITS-1:0];
                    end
                    if (r_shift != '0) begin
                        n_shift = r_shift - SHIFT_BITS'(1);
                    end
                end
            end
            U_DONE: begin
                n_state = U_IDLE;
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_neg   <= n_neg;
        r_shift <= n_shift;
        r_idx   <= n_idx;
    end

    assign o_rsp.done = (r_state == U_DONE);
    assign o_rsp.idx  = r_idx;

    // mapped index always lands inside the source axis
    `ASSERT_IMPLY(a_idx_in_len, i_clk, i_rst_n, o_rsp.done, LEN_BITS'(r_idx) < i_req.len)
    // reduction finishes as soon as the value drops below the length
    `ASSERT_NEXT(a_red_ends, i_clk, i_rst_n, (r_state == U_RED) && w_less, r_state == U_DONE)

endmodule

// ===== rtl/core/image_border_pad.sv =====
// top level: config registers, item sequencer, axis mapper and frame store
// flow: accept -> prep; a load writes the store in prep if in frame, then returns to idle
// out-of-frame fetch strobes zero from prep; in-frame fetch goes mapx, ygo, mapy, read
// mirror wrap adds steps per axis; new words are taken in the strobe cycle, not while busy
// the wrap loop in the shared axis mapper and the registered store read set the fetch time
// reset: synchronous active low; registers to 64,64,0,0,0,0,0; store contents not cleared
`timescale 1ns / 1ps

module image_border_pad (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ibp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [ibp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_opcode,
    input  logic [ibp_pkg::COORD_BITS-1:0]    i_coord_x,
    input  logic [ibp_pkg::COORD_BITS-1:0]    i_coord_y,
    input  logic [ibp_pkg::PIXEL_BITS-1:0]    i_pixel_in,
    output logic                              o_result_valid,
    output logic [ibp_pkg::PIXEL_BITS-1:0]    o_pixel_out,
    output logic                              o_out_of_range
);
    import ibp_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_MAPX = 6'b000100,
        S_YGO  = 6'b001000,
        S_MAPY = 6'b010000,
        S_READ = 6'b100000
    } t_state;

    t_state                r_state, n_state;

    logic [LEN_BITS-1:0]   r_src_width;
    logic [LEN_BITS-1:0]   r_src_height;
    logic [PAD_BITS-1:0]   r_pad_left;
    logic [PAD_BITS-1:0]   r_pad_right;
    logic [PAD_BITS-1:0]   r_pad_top;
    logic [PAD_BITS-1:0]   r_pad_bottom;
    logic                  r_edge_mode;

    logic                  r_op;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [PIXEL_BITS-1:0] r_pix;
    logic [X_BITS-1:0]     r_sx;

    logic                  r_out_valid, n_out_valid;
    logic [PIXEL_BITS-1:0] r_pixel_out, n_pixel_out;
    logic                  r_oor, n_oor;

    logic                  w_accept;
    logic [LEN_BITS-1:0]   w_w;
    logic [LEN_BITS-1:0]   w_h;
    logic [PAD_BITS-1:0]   w_pl;
    logic [PAD_BITS-1:0]   w_pr;
    logic [PAD_BITS-1:0]   w_pt;
    logic [PAD_BITS-1:0]   w_pb;
    logic [COORD_BITS:0]   w_pad_w;
    logic [COORD_BITS:0]   w_pad_h;
    logic                  w_fetch_oor;
    logic                  w_load_ok;
    logic                  w_sel_y;
    logic                  w_axis_start;
    t_axis_req             w_axis_req;
    t_axis_rsp             w_axis_rsp;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic [ADDR_BITS-1:0]  w_wr_addr;
    logic [ADDR_BITS-1:0]  w_rd_addr;
    logic [PIXEL_BITS-1:0] w_rd_data;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= LEN_BITS'(MAX_WIDTH);
            r_src_height <= LEN_BITS'(MAX_HEIGHT);
            r_pad_left   <= '0;
            r_pad_right  <= '0;
            r_pad_top    <= '0;
            r_pad_bottom <= '0;
            r_edge_mode  <= EDGE_REPLICATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[LEN_BITS-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[LEN_BITS-1:0];
                CFG_PAD_LEFT:   r_pad_left   <= i_cfg_data[PAD_BITS-1:0];
                CFG_PAD_RIGHT:  r_pad_right  <= i_cfg_data[PAD_BITS-1:0];
                CFG_PAD_TOP:    r_pad_top    <= i_cfg_data[PAD_BITS-1:0];
                CFG_PAD_BOTTOM: r_pad_bottom <= i_cfg_data[PAD_BITS-1:0];
                CFG_EDGE_MODE:  r_edge_mode  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // effective geometry
    assign w_w  = clamp_len(r_src_width, LEN_BITS'(MAX_WIDTH));
    assign w_h  = clamp_len(r_src_height, LEN_BITS'(MAX_HEIGHT));
    assign w_pl = clamp_pad(r_pad_left);
    assign w_pr = clamp_pad(r_pad_right);
    assign w_pt = clamp_pad(r_pad_top);
    assign w_pb = clamp_pad(r_pad_bottom);

    assign w_pad_w = (COORD_BITS + 1)'(w_pl) + (COORD_BITS + 1)'(w_w) + (COORD_BITS + 1)'(w_pr);
    assign w_pad_h = (COORD_BITS + 1)'(w_pt) + (COORD_BITS + 1)'(w_h) + (COORD_BITS + 1)'(w_pb);
    assign w_fetch_oor = ((COORD_BITS + 1)'(r_cx) >= w_pad_w)
                      || ((COORD_BITS + 1)'(r_cy) >= w_pad_h);
    assign w_load_ok   = ((COORD_BITS + 1)'(r_cx) < (COORD_BITS + 1)'(w_w))
                      && ((COORD_BITS + 1)'(r_cy) < (COORD_BITS + 1)'(w_h));

    // latch the accepted word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_opcode;
            r_cx  <= i_coord_x;
            r_cy  <= i_coord_y;
            r_pix <= i_pixel_in;
        end
        if ((r_state == S_MAPX) && w_axis_rsp.done) begin
            r_sx <= w_axis_rsp.idx[X_BITS-1:0];
        end
    end

    // shared axis mapper operands, x first then y
    assign w_sel_y          = (r_state == S_YGO) || (r_state == S_MAPY);
    assign w_axis_req.d     = w_sel_y ? r_cy : r_cx;
    assign w_axis_req.pad   = w_sel_y ? w_pt : w_pl;
    assign w_axis_req.len   = w_sel_y ? w_h : w_w;
    assign w_axis_req.mirror = r_edge_mode;
    assign w_axis_start     = ((r_state == S_PREP) && (r_op == OP_FETCH) && !w_fetch_oor)
                           || (r_state == S_YGO);

    ibp_axis_unit u_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_axis_start),
        .i_req   (w_axis_req),
        .o_rsp   (w_axis_rsp)
    );

    // frame store access
    assign w_wr_en   = (r_state == S_PREP) && (r_op == OP_LOAD) && w_load_ok;
    assign w_wr_addr = {r_cy[Y_BITS-1:0], r_cx[X_BITS-1:0]};
    assign w_rd_en   = (r_state == S_MAPY) && w_axis_rsp.done;
    assign w_rd_addr = {w_axis_rsp.idx[Y_BITS-1:0], r_sx};

    ibp_frame_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_pix),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // item sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = 1'b0;
        n_pixel_out = r_pixel_out;
        n_oor       = r_oor;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                priority if (r_op == OP_LOAD) begin
                    n_state = S_IDLE;
                end else if (w_fetch_oor) begin
                    n_out_valid = 1'b1;
                    n_pixel_out = '0;
                    n_oor       = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_MAPX;
                end
            end
            S_MAPX: begin
                if (w_axis_rsp.done) begin
                    n_state = S_YGO;
                end
            end
            S_YGO: begin
                n_state = S_MAPY;
            end
            S_MAPY: begin
                if (w_axis_rsp.done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_pixel_out = w_rd_data;
                n_oor       = 1'b0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        r_pixel_out <= n_pixel_out;
        r_oor       <= n_oor;
    end

    assign o_result_valid = r_out_valid;
    assign o_pixel_out    = r_pixel_out;
    assign o_out_of_range = r_oor;

    // strobe only appears once the sequencer is back at rest
    `ASSERT_IMPLY(a_strobe_idle, i_clk, i_rst_n, r_out_valid, r_state == S_IDLE)
    // a store read always produces an in-frame result next cycle
    `ASSERT_NEXT(a_read_result, i_clk, i_rst_n, r_state == S_READ, r_out_valid && !r_oor)
    // out-of-frame results carry a zero pixel
    `ASSERT_IMPLY(a_oor_zero, i_clk, i_rst_n, r_out_valid && r_oor, r_pixel_out == '0)

endmodule
